// ===== rtl/fphs_pkg.sv =====
// Shared types, constants and saturating helpers for the four-point
// homography solver. No dependencies.
package fphs_pkg;

  localparam int unsigned Rows  = 8;
  localparam int unsigned Cols  = 9;
  localparam int unsigned Words = 16;

  // Kind of one output word of the transposed 4x4 matrix
  typedef enum logic [1:0] {
    WK_ZERO   = 2'd0,
    WK_MATRIX = 2'd1,
    WK_ONE    = 2'd2
  } word_kind_e;

  typedef struct packed {
    word_kind_e  kind;
    logic [2:0]  row;
  } word_src_t;

  // Map an output word position onto its source row of the solution column
  function automatic word_src_t word_src(input logic [3:0] w);
    word_src_t s;
    s.kind = WK_MATRIX;
    s.row  = 3'd0;
    case (w)
      4'd0:    s.row = 3'd0;
      4'd1:    s.row = 3'd3;
      4'd3:    s.row = 3'd6;
      4'd4:    s.row = 3'd1;
      4'd5:    s.row = 3'd4;
      4'd7:    s.row = 3'd7;
      4'd12:   s.row = 3'd2;
      4'd13:   s.row = 3'd5;
      4'd15:   s.kind = WK_ONE;
      default: s.kind = WK_ZERO;
    endcase
    return s;
  endfunction

  // Magnitude of a signed 64-bit value; the most negative value maps to 2^63
  function automatic logic [63:0] mag_of(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Apply a sign to a magnitude, saturating at the signed 64-bit range
  function automatic logic [63:0] from_mag(input logic [63:0] mag, input logic neg);
    logic [63:0] r;
    if (neg) begin
      r = mag[63] ? 64'h8000_0000_0000_0000 : (64'd0 - mag);
    end else begin
      r = mag[63] ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
    end
    return r;
  endfunction

  // Saturating a - b
  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] d;
    logic [63:0] r;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) begin
      r = d[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      r = d[63:0];
    end
    return r;
  endfunction

  // Saturating left shift of a narrow signed value into 64 bits
  function automatic logic [63:0] sat_shl(input logic signed [32:0] v, input int unsigned sh);
    logic [32:0] m;
    logic [63:0] m64;
    logic [63:0] lim;
    logic [63:0] r;
    m   = v[32] ? (33'd0 - v) : v;
    m64 = {31'd0, m};
    lim = 64'h7FFF_FFFF_FFFF_FFFF >> sh;
    if (m64 > lim) begin
      r = v[32] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      r = v[32] ? (64'd0 - (m64 << sh)) : (m64 << sh);
    end
    return r;
  endfunction

endpackage

// ===== rtl/fphs_mul.sv =====
// Fixed-point multiplier: 64x64 magnitude product from four 32x32 partial
// products, round half away from zero, saturate. Uses fphs_pkg.
module fphs_mul #(
  parameter int unsigned COEFF_FRAC_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic [63:0]  x_q, y_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic         busy_q;
  logic         done_q;
  logic [63:0]  p_q;

  logic [31:0]  xs, ys;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] rsum;
  logic [63:0]  rmag;
  logic         rovf;

  // Select one partial product per step
  always_comb begin
    xs    = step_q[0] ? x_q[63:32] : x_q[31:0];
    ys    = step_q[1] ? y_q[63:32] : y_q[31:0];
    pp    = {32'd0, xs} * {32'd0, ys};
    pp_sh = {64'd0, pp} << (7'd32 * ({6'd0, step_q[0]} + {6'd0, step_q[1]}));
    rsum  = acc_q + (128'd1 << (COEFF_FRAC_BITS - 1));
    rmag  = rsum[COEFF_FRAC_BITS + 63 : COEFF_FRAC_BITS];
    rovf  = |rsum[127 : COEFF_FRAC_BITS + 64];
  end

  // Step control: count through the partial-product steps, then flag done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd0;
      end else if (busy_q) begin
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= fphs_pkg::mag_of(a_i);
      y_q   <= fphs_pkg::mag_of(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q == 3'd4) begin
        p_q <= rovf ? (neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                    : fphs_pkg::from_mag(rmag, neg_q);
      end else begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("multiplier restarted while busy");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= 3'd4) else $error("multiplier step out of range");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("multiplier done while busy");
`endif

endmodule

// ===== rtl/fphs_div.sv =====
// Fixed-point row divider: (a << F) / p by restoring long division, one
// quotient bit per cycle, rounded half away from zero. Uses fphs_pkg.
module fphs_div #(
  parameter int unsigned COEFF_FRAC_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] p_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  localparam int unsigned NumW = 64 + COEFF_FRAC_BITS;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q;
  logic [NumW-1:0] quo_q;
  logic [63:0]     rem_q;
  logic [63:0]     d_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [63:0]     q_q;

  logic [64:0]     rx;
  logic            take;
  logic [64:0]     rx_sub;
  logic            rnd;
  logic [NumW:0]   qr;
  logic            qovf;

  // One restoring step and the final rounding
  always_comb begin
    rx     = {rem_q, num_q[NumW-1]};
    take   = rx >= {1'b0, d_q};
    rx_sub = rx - {1'b0, d_q};
    rnd    = {rem_q, 1'b0} >= {1'b0, d_q};
    qr     = {1'b0, quo_q} + {{NumW{1'b0}}, rnd};
    qovf   = |qr[NumW:64];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CntW'(1);
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {fphs_pkg::mag_of(a_i), {COEFF_FRAC_BITS{1'b0}}};
      d_q   <= fphs_pkg::mag_of(p_i);
      neg_q <= a_i[63] ^ p_i[63];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        q_q <= qovf ? (neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                    : fphs_pkg::from_mag(qr[63:0], neg_q);
      end else begin
        num_q <= {num_q[NumW-2:0], 1'b0};
        rem_q <= take ? rx_sub[63:0] : rx[63:0];
        quo_q <= {quo_q[NumW-2:0], take};
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_nonzero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> p_i != 64'd0) else $error("divider started with zero pivot");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !$rose(busy_q) |-> rem_q < d_q) else $error("remainder not below divisor");
`endif

endmodule

// ===== rtl/four_point_homography_solver_top.sv =====
// Top level of the four-point homography solver: point capture, matrix
// memory, solve sequencer and output stage. Uses fphs_pkg, fphs_mul, fphs_div.
//
//  channel | dir | tdata                                  | tlast     | tuser
//  s_axis  | in  | src_x, src_y, dst_x, dst_y (16 b each) | -         | -
//  m_axis  | out | coeff[63:0], word_index[67:64], pad    | last_word | singular
//
// Points are taken while idle; the fourth starts a solve over an 8x9 system
// in a 72-entry memory: a build pass, then nine divisions per pivot row
// through the serial divider and each multiply-subtract through the serial
// multiplier, then 16 output words, each handed out before the next is read.
// Reset clears the point count and all control; the memory is not cleared.
// Input is stalled from the fourth point until the sixteenth word is taken.
module four_point_homography_solver_top #(
  parameter int unsigned COEFF_FRAC_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // src_x, src_y, dst_x, dst_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // coeff, word_index, zero pad
  output logic        m_axis_tlast,   // last_word
  output logic        m_axis_tuser    // singular
);

  typedef enum logic [4:0] {
    S_IDLE, S_BUILD, S_COL, S_PIV_CMP, S_PIV_DEC,
    S_SWAP_RD, S_SWAP_WA, S_SWAP_WB,
    S_DIV_RD, S_DIV_GO, S_DIV_WT,
    S_ELF_RD, S_ELF_LD, S_EL_RD, S_EL_GO, S_EL_WT,
    S_BK_RD0, S_BK_LD, S_BK_RD, S_BK_GO, S_BK_WT, S_BK_WR,
    S_OUT_RD, S_OUT_LD, S_OUT_WT
  } state_e;

  localparam logic [63:0] One = 64'd1 << COEFF_FRAC_BITS;

  state_e      state_q;
  logic [1:0]  pts_q;
  logic [63:0] point_q [4];
  logic        sing_q;
  logic [2:0]  br_q;
  logic [3:0]  bc_q;
  logic [3:0]  row_q;
  logic [3:0]  col_q;
  logic [3:0]  k_q;
  logic [2:0]  u_q;
  logic [2:0]  kc_q;
  logic [2:0]  best_q;
  logic [63:0] bmag_q;
  logic [63:0] piv_q;
  logic [63:0] f_q;
  logic [63:0] acc_q;
  logic [2:0]  i_q;
  logic [2:0]  j_q;
  logic [3:0]  w_q;
  logic        ovalid_q;
  logic [63:0] ocoeff_q;

  // Matrix memory: one write port, two registered read ports
  logic [63:0] mat_mem [72];
  logic        we;
  logic [6:0]  wa;
  logic [63:0] wd;
  logic        re;
  logic [6:0]  ra0, ra1;
  logic [63:0] rd0_q, rd1_q;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, mul_p, div_q;

  logic [63:0] bval;
  logic [63:0] cmag;
  fphs_pkg::word_src_t ws;

  function automatic logic [6:0] maddr(input logic [2:0] r, input logic [3:0] c);
    return {1'b0, r, 3'b000} + {4'd0, r} + {3'd0, c};
  endfunction

  // Build one system entry from the stored point of row br_q
  always_comb begin
    logic [63:0]        pt;
    logic signed [15:0] sx, sy, dd;
    logic signed [32:0] sxd, syd;
    logic [63:0]        fsx, fsy;
    pt   = point_q[br_q[2:1]];
    sx   = pt[15:0];
    sy   = pt[31:16];
    dd   = br_q[0] ? pt[63:48] : pt[47:32];
    sxd  = 33'(sx * dd);
    syd  = 33'(sy * dd);
    fsx  = fphs_pkg::sat_shl(-33'(sx), COEFF_FRAC_BITS - 4);
    fsy  = fphs_pkg::sat_shl(-33'(sy), COEFF_FRAC_BITS - 4);
    bval = 64'd0;
    case (bc_q)
      4'd0: bval = br_q[0] ? 64'd0 : fsx;
      4'd1: bval = br_q[0] ? 64'd0 : fsy;
      4'd2: bval = br_q[0] ? 64'd0 : (64'd0 - One);
      4'd3: bval = br_q[0] ? fsx : 64'd0;
      4'd4: bval = br_q[0] ? fsy : 64'd0;
      4'd5: bval = br_q[0] ? (64'd0 - One) : 64'd0;
      4'd6: bval = fphs_pkg::sat_shl(sxd, COEFF_FRAC_BITS - 8);
      4'd7: bval = fphs_pkg::sat_shl(syd, COEFF_FRAC_BITS - 8);
      4'd8: bval = fphs_pkg::sat_shl(-33'(dd), COEFF_FRAC_BITS - 4);
      default: bval = 64'd0;
    endcase
  end

  assign cmag = fphs_pkg::mag_of(rd0_q);
  assign ws   = fphs_pkg::word_src(w_q);

  // Memory port control and multiplier and divider starts per state
  always_comb begin
    we  = 1'b0;
    wa  = '0;
    wd  = '0;
    re  = 1'b0;
    ra0 = '0;
    ra1 = '0;
    mul_start = 1'b0;
    mul_a = rd0_q;
    mul_b = rd1_q;
    div_start = 1'b0;
    case (state_q)
      S_BUILD: begin
        we = 1'b1; wa = maddr(br_q, bc_q); wd = bval;
      end
      S_COL: begin
        re = (row_q < 4'd8) && (col_q < 4'd9); ra0 = maddr(row_q[2:0], col_q);
      end
      S_PIV_CMP: begin
        re = kc_q != 3'd7; ra0 = maddr(kc_q + 3'd1, col_q);
      end
      S_SWAP_RD: begin
        re = 1'b1; ra0 = maddr(row_q[2:0], k_q); ra1 = maddr(best_q, k_q);
      end
      S_SWAP_WA: begin
        we = 1'b1; wa = maddr(row_q[2:0], k_q); wd = rd1_q;
      end
      S_SWAP_WB: begin
        we = 1'b1; wa = maddr(best_q, k_q); wd = rd0_q;
      end
      S_DIV_RD: begin
        re = 1'b1; ra0 = maddr(row_q[2:0], k_q);
      end
      S_DIV_GO: div_start = 1'b1;
      S_DIV_WT: begin
        we = div_done; wa = maddr(row_q[2:0], k_q); wd = div_q;
      end
      S_ELF_RD: begin
        re = 1'b1; ra0 = maddr(u_q, col_q);
      end
      S_EL_RD: begin
        re = 1'b1; ra0 = maddr(row_q[2:0], k_q); ra1 = maddr(u_q, k_q);
      end
      S_EL_GO: begin
        mul_start = 1'b1; mul_a = f_q; mul_b = rd0_q;
      end
      S_EL_WT: begin
        we = mul_done; wa = maddr(u_q, k_q); wd = fphs_pkg::sat_sub(rd1_q, mul_p);
      end
      S_BK_RD0: begin
        re = 1'b1; ra0 = maddr(i_q, 4'd8);
      end
      S_BK_RD: begin
        re = 1'b1; ra0 = maddr(i_q, {1'b0, j_q}); ra1 = maddr(j_q, 4'd8);
      end
      S_BK_GO: mul_start = 1'b1;
      S_BK_WR: begin
        we = 1'b1; wa = maddr(i_q, 4'd8); wd = acc_q;
      end
      S_OUT_RD: begin
        re = ws.kind == fphs_pkg::WK_MATRIX; ra0 = maddr(ws.row, 4'd8);
      end
      default: ;
    endcase
  end

  // Matrix memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mat_mem[wa] <= wd;
    end
    if (re) begin
      rd0_q <= mat_mem[ra0];
      rd1_q <= mat_mem[ra1];
    end
  end

  // Capture points
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      point_q[pts_q] <= s_axis_tdata;
    end
  end

  // Solve sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pts_q    <= 2'd0;
      sing_q   <= 1'b0;
      ovalid_q <= 1'b0;
      br_q <= '0; bc_q <= '0; row_q <= '0; col_q <= '0; k_q <= '0;
      u_q <= '0; kc_q <= '0; best_q <= '0; i_q <= '0; j_q <= '0; w_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pts_q <= pts_q + 2'd1;
            if (pts_q == 2'd3) begin
              sing_q  <= 1'b0;
              br_q    <= '0;
              bc_q    <= '0;
              state_q <= S_BUILD;
            end
          end
        end
        S_BUILD: begin
          if (bc_q == 4'd8) begin
            bc_q <= '0;
            br_q <= br_q + 3'd1;
            if (br_q == 3'd7) begin
              row_q   <= '0;
              col_q   <= '0;
              state_q <= S_COL;
            end
          end else begin
            bc_q <= bc_q + 4'd1;
          end
        end
        S_COL: begin
          if (row_q == 4'd8 || col_q == 4'd9) begin
            i_q     <= 3'd6;
            state_q <= S_BK_RD0;
          end else begin
            kc_q    <= row_q[2:0];
            state_q <= S_PIV_CMP;
          end
        end
        S_PIV_CMP: begin
          if ({1'b0, kc_q} == row_q || cmag > bmag_q) begin
            best_q <= kc_q;
            bmag_q <= cmag;
            piv_q  <= rd0_q;
          end
          if (kc_q == 3'd7) begin
            state_q <= S_PIV_DEC;
          end else begin
            kc_q <= kc_q + 3'd1;
          end
        end
        S_PIV_DEC: begin
          k_q <= '0;
          if (piv_q == 64'd0) begin
            sing_q  <= 1'b1;
            col_q   <= col_q + 4'd1;
            state_q <= S_COL;
          end else if ({1'b0, best_q} != row_q) begin
            state_q <= S_SWAP_RD;
          end else begin
            state_q <= S_DIV_RD;
          end
        end
        S_SWAP_RD: state_q <= S_SWAP_WA;
        S_SWAP_WA: state_q <= S_SWAP_WB;
        S_SWAP_WB: begin
          if (k_q == 4'd8) begin
            k_q     <= '0;
            state_q <= S_DIV_RD;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= S_SWAP_RD;
          end
        end
        S_DIV_RD: state_q <= S_DIV_GO;
        S_DIV_GO: state_q <= S_DIV_WT;
        S_DIV_WT: begin
          if (div_done) begin
            if (k_q == 4'd8) begin
              k_q <= '0;
              if (row_q == 4'd7) begin
                row_q   <= row_q + 4'd1;
                col_q   <= col_q + 4'd1;
                state_q <= S_COL;
              end else begin
                u_q     <= row_q[2:0] + 3'd1;
                state_q <= S_ELF_RD;
              end
            end else begin
              k_q     <= k_q + 4'd1;
              state_q <= S_DIV_RD;
            end
          end
        end
        S_ELF_RD: state_q <= S_ELF_LD;
        S_ELF_LD: begin
          f_q     <= rd0_q;
          k_q     <= '0;
          state_q <= S_EL_RD;
        end
        S_EL_RD: state_q <= S_EL_GO;
        S_EL_GO: state_q <= S_EL_WT;
        S_EL_WT: begin
          if (mul_done) begin
            if (k_q == 4'd8) begin
              if (u_q == 3'd7) begin
                row_q   <= row_q + 4'd1;
                col_q   <= col_q + 4'd1;
                state_q <= S_COL;
              end else begin
                u_q     <= u_q + 3'd1;
                state_q <= S_ELF_RD;
              end
            end else begin
              k_q     <= k_q + 4'd1;
              state_q <= S_EL_RD;
            end
          end
        end
        S_BK_RD0: state_q <= S_BK_LD;
        S_BK_LD: begin
          acc_q   <= rd0_q;
          j_q     <= i_q + 3'd1;
          state_q <= S_BK_RD;
        end
        S_BK_RD: state_q <= S_BK_GO;
        S_BK_GO: state_q <= S_BK_WT;
        S_BK_WT: begin
          if (mul_done) begin
            acc_q <= fphs_pkg::sat_sub(acc_q, mul_p);
            if (j_q == 3'd7) begin
              state_q <= S_BK_WR;
            end else begin
              j_q     <= j_q + 3'd1;
              state_q <= S_BK_RD;
            end
          end
        end
        S_BK_WR: begin
          if (i_q == 3'd0) begin
            w_q     <= '0;
            state_q <= S_OUT_RD;
          end else begin
            i_q     <= i_q - 3'd1;
            state_q <= S_BK_RD0;
          end
        end
        S_OUT_RD: state_q <= S_OUT_LD;
        S_OUT_LD: begin
          unique case (ws.kind)
            fphs_pkg::WK_MATRIX: ocoeff_q <= rd0_q;
            fphs_pkg::WK_ONE:    ocoeff_q <= One;
            default:             ocoeff_q <= 64'd0;
          endcase
          ovalid_q <= 1'b1;
          state_q  <= S_OUT_WT;
        end
        S_OUT_WT: begin
          if (m_axis_tready) begin
            ovalid_q <= 1'b0;
            if (w_q == 4'd15) begin
              state_q <= S_IDLE;
            end else begin
              w_q     <= w_q + 4'd1;
              state_q <= S_OUT_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  fphs_mul #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  fphs_div #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (rd0_q),
    .p_i     (piv_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'd0, w_q, ocoeff_q};
  assign m_axis_tlast  = w_q == 4'd15;
  assign m_axis_tuser  = sing_q;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken while word pending");
  a_valid_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> state_q == S_OUT_WT) else $error("output valid outside output wait");
  a_last_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("block not idle after last word");
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> wa < 7'd72) else $error("matrix write out of range");
  a_solve_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && pts_q == 2'd3 |=> state_q == S_BUILD && !sing_q)
    else $error("solve did not start on fourth point");
`endif

endmodule

// ===== test/homography_checker.sv =====
// Checker for the four-point homography solver: watches both stream channels,
// predicts the 16 matrix words of every fourth point and compares them.
// Depends on nothing but the stream port widths of the block.
module homography_checker #(
  parameter int unsigned FRAC = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  output int          errors_o,
  output int          pending_o,
  output int          solves_o,
  output int          singular_solves_o
);

  localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint MIN64 = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [63:0] coeff;
    logic [3:0]  word_index;
    logic        last_word;
    logic        singular;
  } matrix_word_t;

  matrix_word_t expected_words[$];
  logic [63:0]  point_regs[4];
  int           points_held;

  function automatic logic [63:0] abs64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint apply_sign(input logic [63:0] mg, input logic neg);
    if (neg) return mg[63] ? MIN64 : -longint'(mg);
    return mg[63] ? MAX64 : longint'(mg);
  endfunction

  function automatic longint shl_sat(input longint v, input int sh);
    logic [63:0] mg;
    mg = abs64(v);
    if (mg > (64'h7FFF_FFFF_FFFF_FFFF >> sh)) return v < 0 ? MIN64 : MAX64;
    return apply_sign(mg << sh, v < 0);
  endfunction

  function automatic longint sub_sat(input longint a, input longint b);
    logic signed [64:0] d;
    d = 65'(a) - 65'(b);
    if (d > 65'(MAX64)) return MAX64;
    if (d < 65'(MIN64)) return MIN64;
    return longint'(d);
  endfunction

  // Full-width product, rounded half away from zero, then saturated
  function automatic longint mul_q(input longint a, input longint b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
    if (p[127:64] != 0) return ((a < 0) != (b < 0)) ? MIN64 : MAX64;
    return apply_sign(p[63:0], (a < 0) != (b < 0));
  endfunction

  // (a << FRAC) / p, rounded half away from zero, then saturated
  function automatic longint div_q(input longint a, input longint p);
    logic [127:0] n, d, q, r;
    n = {64'd0, abs64(a)} << FRAC;
    d = {64'd0, abs64(p)};
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    if (q[127:64] != 0) return ((a < 0) != (p < 0)) ? MIN64 : MAX64;
    return apply_sign(q[63:0], (a < 0) != (p < 0));
  endfunction

  // Build and solve the 8x9 system, then queue the 16 transposed words
  task automatic solve_homography();
    longint       m[8][9];
    longint       sx, sy, dx, dy, fsx, fsy, one, piv, f, t;
    int           row, col, best;
    logic         sing;
    matrix_word_t w;
    one = longint'(1) <<< FRAC;
    for (int p = 0; p < 4; p++) begin
      sx  = longint'($signed(point_regs[p][15:0]));
      sy  = longint'($signed(point_regs[p][31:16]));
      dx  = longint'($signed(point_regs[p][47:32]));
      dy  = longint'($signed(point_regs[p][63:48]));
      fsx = shl_sat(-sx, FRAC - 4);
      fsy = shl_sat(-sy, FRAC - 4);
      m[2*p] = '{fsx, fsy, -one, 0, 0, 0, shl_sat(sx * dx, FRAC - 8),
                 shl_sat(sy * dx, FRAC - 8), shl_sat(-dx, FRAC - 4)};
      m[2*p+1] = '{0, 0, 0, fsx, fsy, -one, shl_sat(sx * dy, FRAC - 8),
                   shl_sat(sy * dy, FRAC - 8), shl_sat(-dy, FRAC - 4)};
    end
    sing = 1'b0;
    row  = 0;
    col  = 0;
    // Forward elimination with partial pivoting; skip a zero column
    while (row < 8 && col < 9) begin
      best = row;
      for (int k = row + 1; k < 8; k++)
        if (abs64(m[k][col]) > abs64(m[best][col])) best = k;
      if (m[best][col] != 0) begin
        for (int k = 0; k < 9; k++) begin
          t = m[row][k]; m[row][k] = m[best][k]; m[best][k] = t;
        end
        piv = m[row][col];
        for (int k = 0; k < 9; k++) m[row][k] = div_q(m[row][k], piv);
        for (int u = row + 1; u < 8; u++) begin
          f = m[u][col];
          for (int k = 0; k < 9; k++) m[u][k] = sub_sat(m[u][k], mul_q(f, m[row][k]));
        end
        row++;
      end else begin
        sing = 1'b1;
      end
      col++;
    end
    // Back substitution on the right-hand column
    for (int i = 6; i >= 0; i--)
      for (int j = i + 1; j < 8; j++) m[i][8] = sub_sat(m[i][8], mul_q(m[i][j], m[j][8]));
    for (int k = 0; k < 16; k++) begin
      w.word_index = 4'(k);
      w.last_word  = (k == 15);
      w.singular   = sing;
      case (k)
        0:       w.coeff = m[0][8];
        1:       w.coeff = m[3][8];
        3:       w.coeff = m[6][8];
        4:       w.coeff = m[1][8];
        5:       w.coeff = m[4][8];
        7:       w.coeff = m[7][8];
        12:      w.coeff = m[2][8];
        13:      w.coeff = m[5][8];
        15:      w.coeff = one;
        default: w.coeff = '0;
      endcase
      expected_words.push_back(w);
    end
    solves_o++;
    if (sing) singular_solves_o++;
  endtask

  // Track accepted points and compare every output beat
  always @(posedge clk_i or negedge rst_ni) begin
    matrix_word_t e;
    if (!rst_ni) begin
      points_held       = 0;
      errors_o          = 0;
      solves_o          = 0;
      singular_solves_o = 0;
      expected_words.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        point_regs[points_held] = s_axis_tdata;
        if (points_held == 3) begin
          points_held = 0;
          solve_homography();
        end else begin
          points_held++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output beat, coeff %h", m_axis_tdata[63:0]);
          errors_o++;
        end else begin
          e = expected_words.pop_front();
          if (m_axis_tdata[63:0] !== e.coeff) begin
            $error("coeff: expected %h, got %h", e.coeff, m_axis_tdata[63:0]);
            errors_o++;
          end
          if (m_axis_tdata[67:64] !== e.word_index) begin
            $error("word_index: expected %0d, got %0d", e.word_index, m_axis_tdata[67:64]);
            errors_o++;
          end
          if (m_axis_tlast !== e.last_word) begin
            $error("last_word: expected %b, got %b", e.last_word, m_axis_tlast);
            errors_o++;
          end
          if (m_axis_tuser !== e.singular) begin
            $error("singular: expected %b, got %b", e.singular, m_axis_tuser);
            errors_o++;
          end
        end
      end
    end
    pending_o = expected_words.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the homography solver testbench: clock, reset, point stimulus and
// output back-pressure. Uses four_point_homography_solver_top and homography_checker.
module testbench;

  localparam int unsigned FRAC       = 40;
  localparam int          CYCLE_CAP  = 3_000_000;
  localparam int          RAND_SETS  = 58;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  int          errors, pending, solves, singular_solves;
  int          cycles = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  four_point_homography_solver_top #(.COEFF_FRAC_BITS(FRAC)) DUT (.*);

  homography_checker #(.FRAC(FRAC)) u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending), .solves_o(solves),
    .singular_solves_o(singular_solves)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Random idling on either side, except in a quiet window with no idling
  function automatic logic idle_now();
    return (cycles < 150_000 || cycles > 250_000) && ($urandom_range(99) < 14);
  endfunction

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL four_point_homography_solver_top");
      $finish;
    end
  end

  // Output back-pressure, with one long hold once the second solve is in flight
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && solves == 2) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 30_000;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= rst_ni && !idle_now();
    end
  end

  // Offer one point and hold it until the beat is taken
  task automatic send_point(input logic [15:0] sx, sy, dx, dy);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dy, dx, sy, sx};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    if (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Wait until every expected word has come, sampling away from the edge
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Random quadrilateral mapped onto a shifted, jittered copy of itself
  task automatic send_quad();
    int cx, cy, hs, ox, oy, x, y;
    cx = $urandom_range(8000) - 4000;
    cy = $urandom_range(8000) - 4000;
    hs = $urandom_range(16, 800);
    ox = $urandom_range(4000) - 2000;
    oy = $urandom_range(4000) - 2000;
    for (int c = 0; c < 4; c++) begin
      x = cx + ((c == 1 || c == 2) ? hs : -hs) + $urandom_range(hs / 4);
      y = cy + ((c >= 2) ? hs : -hs) + $urandom_range(hs / 4);
      send_point(16'(x), 16'(y), 16'(x + ox + $urandom_range(hs / 2)),
                 16'(y + oy + $urandom_range(hs / 2)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All points at the origin: zero pivot columns, a singular system
    repeat (4) send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // Square of side 16 onto itself
    send_point(16'd0, 16'd0, 16'd0, 16'd0);
    send_point(16'd16, 16'd0, 16'd16, 16'd0);
    send_point(16'd16, 16'd16, 16'd16, 16'd16);
    send_point(16'd0, 16'd16, 16'd0, 16'd16);
    // Coordinate extremes, driving saturation
    send_point(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_point(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_point(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_point(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    // Square onto a scaled and shifted quadrilateral
    send_point(16'd0, 16'd0, 16'd100, 16'd50);
    send_point(16'd160, 16'd0, 16'd420, 16'd70);
    send_point(16'd160, 16'd160, 16'd400, 16'd390);
    send_point(16'd0, 16'd160, 16'd90, 16'd380);
    // One point repeated: rank-deficient system
    repeat (4) send_point(16'd320, 16'hFF00, 16'd48, 16'd96);

    for (int n = 0; n < RAND_SETS; n++) begin
      if (n == RAND_SETS / 2) begin
        // Let the block drain completely before going on
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      if ($urandom_range(99) < 80) begin
        send_quad();
      end else begin
        repeat (4) send_point(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Ran %0d solves (%0d singular), directed extremes plus random quads and noise.",
             solves, singular_solves);
    if (errors == 0 && pending == 0) begin
      $display("PASS four_point_homography_solver_top");
    end else begin
      $display("FAIL four_point_homography_solver_top");
    end
    $finish;
  end

endmodule
